>>> hdl/alpd_pkg.sv
// shared types and constants of the ascii length-prefixed deframer
`default_nettype none
package alpd_pkg;

	localparam int BYTE_W         = 8;
	localparam int ACC_W          = 20;
	localparam int TYPE_W         = 15;
	localparam int LEN_W          = 20;
	localparam int OUT_DATA_W     = 48;
	localparam int OUT_USER_W     = 4;
	localparam int TYPE_CHARS_DEF = 4;
	localparam int LENGTH_CHARS_DEF = 6;

	localparam logic [ACC_W-1:0]  ACC_MAX      = 20'hFFFFF;
	localparam logic [ACC_W-1:0]  TYPE_POS_MAX = 20'd16383;
	localparam logic [ACC_W-1:0]  TYPE_NEG_MAX = 20'd16384;

	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_TYPE   = 2'd1,
		ERR_LENGTH = 2'd2
	} err_t;

	// running state of one header field
	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic             negative;
		logic             has_digit;
		logic             stopped;
		logic             started;
	} field_t;

endpackage
`default_nettype wire

>>> hdl/alpd_field.sv
// stoi-style decimal field parser, one character per step
`default_nettype none
module alpd_field (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic                       clear,
	input  wire logic [alpd_pkg::BYTE_W-1:0] char_in,
	output alpd_pkg::field_t                parsed
);

	alpd_pkg::field_t field_q;
	logic             is_digit;
	logic             is_space;
	logic             is_sign;
	logic [3:0]       digit;
	logic [alpd_pkg::ACC_W+3:0] prod;

	assign is_digit = (char_in >= alpd_pkg::CHAR_ZERO) && (char_in <= alpd_pkg::CHAR_NINE);
	assign is_space = (char_in == alpd_pkg::CHAR_SPACE) ||
		((char_in >= alpd_pkg::CHAR_TAB) && (char_in <= alpd_pkg::CHAR_CR));
	assign is_sign  = (char_in == alpd_pkg::CHAR_PLUS) || (char_in == alpd_pkg::CHAR_MINUS);
	assign digit    = 4'(char_in - alpd_pkg::CHAR_ZERO);

	// acc * 10 + digit by shift and add
	assign prod = {1'b0, field_q.acc, 3'b000} + {3'b000, field_q.acc, 1'b0}
		+ {(alpd_pkg::ACC_W)'(0), digit};

	always_comb begin
		parsed = field_q;
		if (!field_q.stopped) begin
			priority if (is_digit) begin
				parsed.started   = 1'b1;
				parsed.has_digit = 1'b1;
				if (prod > {4'b0000, alpd_pkg::ACC_MAX}) begin
					parsed.acc = alpd_pkg::ACC_MAX;
				end else begin
					parsed.acc = prod[alpd_pkg::ACC_W-1:0];
				end
			end else if (!field_q.started && is_space) begin
				parsed = field_q;
			end else if (!field_q.started && is_sign) begin
				parsed.started  = 1'b1;
				parsed.negative = (char_in == alpd_pkg::CHAR_MINUS);
			end else begin
				parsed.stopped = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= '0;
		end else if (step) begin
			if (clear) begin
				field_q <= '0;
			end else begin
				field_q <= parsed;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/ascii_length_prefixed_deframer.sv
// a byte passes from the input register through the parse step into the result register
// throughput: one byte per cycle while the output is not stalled, header and payload alike,
// set by the single parse step between the input register and the result register
// a stalled output holds one result while the input register takes the next byte
// reset: arst_n clears all control state at once; the block expects a header after reset
`default_nettype none
module ascii_length_prefixed_deframer #(
	parameter int TYPE_CHARS   = alpd_pkg::TYPE_CHARS_DEF,
	parameter int LENGTH_CHARS = alpd_pkg::LENGTH_CHARS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output      logic                              s_axis_tready,
	input  wire logic [alpd_pkg::BYTE_W-1:0]       s_axis_tdata,  // data_byte
	output      logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// payload_byte [7:0], message_type [22:8], message_length [42:23], zero pad
	output      logic [alpd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// first_flag [0], empty_flag [1], error_code [3:2]
	output      logic [alpd_pkg::OUT_USER_W-1:0]   m_axis_tuser,
	output      logic                              m_axis_tlast   // last_flag
);

	localparam int HDR_CHARS = TYPE_CHARS + LENGTH_CHARS;
	localparam int HIDX_W    = $clog2(HDR_CHARS + 1);

	localparam int ACC_W  = alpd_pkg::ACC_W;
	localparam int TYPE_W = alpd_pkg::TYPE_W;
	localparam int LEN_W  = alpd_pkg::LEN_W;
	localparam int BYTE_W = alpd_pkg::BYTE_W;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;

	logic                in_payload_q;
	logic [HIDX_W-1:0]   hidx_q;
	logic [TYPE_W-1:0]   cur_type_q;
	logic [LEN_W-1:0]    cur_len_q;
	logic [LEN_W-1:0]    remaining_q;
	logic                type_error_q;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic [TYPE_W-1:0]   out_type_q;
	logic [LEN_W-1:0]    out_len_q;
	logic                out_first_q;
	logic                out_last_q;
	logic                out_empty_q;
	alpd_pkg::err_t      out_err_q;

	logic                advance;
	logic                hdr_step;
	logic [HIDX_W-1:0]   hidx_inc;
	logic                at_type;
	logic                at_end;
	alpd_pkg::field_t    parsed;
	logic [TYPE_W-1:0]   type_val;
	logic                len_bad;

	logic                res_valid;
	logic [BYTE_W-1:0]   res_byte;
	logic [TYPE_W-1:0]   res_type;
	logic [LEN_W-1:0]    res_len;
	logic                res_first;
	logic                res_last;
	logic                res_empty;
	alpd_pkg::err_t      res_err;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign hdr_step      = advance && !in_payload_q;
	assign hidx_inc      = hidx_q + HIDX_W'(1);
	assign at_type       = (hidx_inc == HIDX_W'(TYPE_CHARS));
	assign at_end        = (hidx_inc == HIDX_W'(HDR_CHARS));

	alpd_field u_field (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (hdr_step),
		.clear   (at_type || at_end),
		.char_in (byte_s1),
		.parsed  (parsed)
	);

	// type field saturates to the signed 15-bit range
	always_comb begin
		if (parsed.negative) begin
			if (parsed.acc > alpd_pkg::TYPE_NEG_MAX) begin
				type_val = TYPE_W'(ACC_W'(0) - alpd_pkg::TYPE_NEG_MAX);
			end else begin
				type_val = TYPE_W'(ACC_W'(0) - parsed.acc);
			end
		end else if (parsed.acc > alpd_pkg::TYPE_POS_MAX) begin
			type_val = TYPE_W'(alpd_pkg::TYPE_POS_MAX);
		end else begin
			type_val = TYPE_W'(parsed.acc);
		end
	end

	// minus zero is a valid zero length
	assign len_bad = !parsed.has_digit || (parsed.negative && (parsed.acc != '0));

	always_comb begin
		res_valid = 1'b0;
		res_byte  = '0;
		res_type  = cur_type_q;
		res_len   = '0;
		res_first = 1'b0;
		res_last  = 1'b1;
		res_empty = 1'b0;
		res_err   = alpd_pkg::ERR_NONE;
		if (in_payload_q) begin
			res_valid = 1'b1;
			res_byte  = byte_s1;
			res_len   = cur_len_q;
			res_first = (remaining_q == cur_len_q);
			res_last  = (remaining_q <= LEN_W'(1));
		end else if (at_end) begin
			priority if (type_error_q) begin
				res_valid = 1'b1;
				res_type  = '0;
				res_err   = alpd_pkg::ERR_TYPE;
			end else if (len_bad) begin
				res_valid = 1'b1;
				res_err   = alpd_pkg::ERR_LENGTH;
			end else if (parsed.acc == '0) begin
				res_valid = 1'b1;
				res_first = 1'b1;
				res_empty = 1'b1;
			end else begin
				res_valid = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hidx_q       <= '0;
			cur_type_q   <= '0;
			cur_len_q    <= '0;
			remaining_q  <= '0;
			type_error_q <= 1'b0;
		end else if (advance) begin
			if (in_payload_q) begin
				if (remaining_q <= LEN_W'(1)) begin
					in_payload_q <= 1'b0;
					remaining_q  <= '0;
				end else begin
					remaining_q <= remaining_q - LEN_W'(1);
				end
			end else if (at_end) begin
				hidx_q <= '0;
				priority if (type_error_q) begin
					type_error_q <= 1'b0;
					cur_type_q   <= '0;
					cur_len_q    <= '0;
				end else if (len_bad) begin
					cur_len_q <= '0;
				end else begin
					cur_len_q    <= parsed.acc;
					remaining_q  <= parsed.acc;
					in_payload_q <= (parsed.acc != '0);
				end
			end else begin
				hidx_q <= hidx_inc;
				if (at_type) begin
					type_error_q <= !parsed.has_digit;
					cur_type_q   <= parsed.has_digit ? type_val : '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_byte_q  <= res_byte;
			out_type_q  <= res_type;
			out_len_q   <= res_len;
			out_first_q <= res_first;
			out_last_q  <= res_last;
			out_empty_q <= res_empty;
			out_err_q   <= res_err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(alpd_pkg::OUT_DATA_W - BYTE_W - TYPE_W - LEN_W)'(0),
		out_len_q, out_type_q, out_byte_q};
	assign m_axis_tuser  = {out_err_q, out_empty_q, out_first_q};
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

>>> hdl/alpd_checker.sv
// port-level checks of the deframer and their binding
`default_nettype none
module alpd_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [alpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [alpd_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input wire logic                            m_axis_tlast
);

	// no transfer offered while in reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	// a stalled transfer holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("stalled output changed");

	// an error result closes the message and carries no byte and no length
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[3:2] != alpd_pkg::ERR_NONE) |->
			m_axis_tlast && !m_axis_tuser[0] && !m_axis_tuser[1]
			&& (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[42:23] == 20'd0))
		else $error("malformed error result");

	// an empty message is a single first and last result of length zero
	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tuser[0] && m_axis_tlast && (m_axis_tuser[3:2] == alpd_pkg::ERR_NONE)
			&& (m_axis_tdata[42:23] == 20'd0))
		else $error("malformed empty result");

	// a first payload byte of a multi-byte message is not also the last
	a_first_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1]
			&& (m_axis_tdata[42:23] > 20'd1) |-> !m_axis_tlast)
		else $error("first byte marked last in long message");

endmodule

bind ascii_length_prefixed_deframer alpd_checker u_alpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
